// File: hw/rtl/mir_pkg.sv
// Package for the median IR distance converter.
// Holds sizes, calibration curve tables and shared types. No dependencies.
package mir_pkg;

  localparam int unsigned SampleCount = 25;
  localparam int unsigned AddrW       = $clog2(SampleCount);
  localparam int unsigned IdxW        = $clog2(SampleCount + 1);
  localparam int unsigned MedRank     = SampleCount / 2;
  localparam int unsigned SampleW     = 10;
  localparam int unsigned ModelW      = 3;
  localparam int unsigned DistW       = 23;
  localparam int unsigned DivW        = 22;
  localparam int unsigned OffW        = 13;
  localparam int unsigned BitW        = $clog2(SampleW);
  localparam int unsigned StepW       = $clog2(DivW);

  localparam logic [DistW-1:0]  DistMax    = 23'h3FFFFF;
  localparam logic [ModelW-1:0] ModelReset = 3'd1;
  localparam logic [ModelW-1:0] ModelFixed = 3'd1;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [ModelW-1:0]  model_t;
  typedef logic [DistW-1:0]   dist_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } rd_req_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkScan,
    BkDiv,
    BkDone
  } back_state_e;

  function automatic logic model_known(model_t m);
    return m inside {[3'd1:3'd6]};
  endfunction

  function automatic logic [DivW-1:0] curve_k(model_t m);
    logic [DivW-1:0] k;
    case (m)
      3'd1:    k = 22'd5732;
      3'd2:    k = 22'd1463667;
      3'd3:    k = 22'd1393236;
      3'd4:    k = 22'd1452103;
      3'd5:    k = 22'd1490931;
      3'd6:    k = 22'd3870139;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [OffW-1:0] curve_off(model_t m);
    logic [OffW-1:0] o;
    case (m)
      3'd1:    o = 13'd959;
      3'd2:    o = 13'd1814;
      3'd3:    o = 13'd1789;
      3'd4:    o = 13'd886;
      3'd5:    o = 13'd1027;
      3'd6:    o = 13'd6171;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// File: hw/rtl/mir_front.sv
// Front end: model register, sample capture into the batch memory, batch counting.
// Depends on mir_pkg.
module mir_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  mir_pkg::model_t  cfg_wdata_i,
  input  logic             in_valid_i,
  input  mir_pkg::sample_t adc_sample_i,
  output logic             in_stall_o,
  input  logic             hold_i,
  output logic             push_o,
  output mir_pkg::model_t  model_o,
  input  mir_pkg::rd_req_t rd_i,
  output mir_pkg::sample_t rd_data_o
);
  import mir_pkg::*;

  model_t           model_q;
  logic [AddrW-1:0] cnt_q, cnt_d;
  sample_t          mem_q [SampleCount];
  sample_t          rd_data_q;
  logic             acc;
  logic             last;

  assign in_stall_o = hold_i;
  assign acc        = in_valid_i & ~hold_i;
  assign last       = (cnt_q == AddrW'(SampleCount - 1));
  assign push_o     = acc & last;
  assign model_o    = model_q;
  assign rd_data_o  = rd_data_q;

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= ModelReset;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) model_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[cnt_q] <= adc_sample_i;
    if (rd_i.en) rd_data_q <= mem_q[rd_i.addr];
  end

endmodule

// File: hw/rtl/mir_queue.sv
// Two-entry queue of batch tokens (model per batch) between front and back.
// Depends on mir_pkg.
module mir_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mir_pkg::model_t push_data_i,
  input  logic            pop_i,
  output mir_pkg::model_t pop_data_o,
  output logic            empty_o
);
  import mir_pkg::*;

  model_t     ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o    = (cnt_q == 2'd0);
  assign do_push    = push_i & (cnt_q != 2'd2);
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wp_q] <= push_data_i;
  end

endmodule

// File: hw/rtl/mir_back.sv
// Back end: bitwise median search over the batch memory, serial divider, result register.
// Depends on mir_pkg.
module mir_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  mir_pkg::model_t  q_model_i,
  output logic             q_pop_o,
  output logic             busy_o,
  output mir_pkg::rd_req_t rd_o,
  input  mir_pkg::sample_t rd_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mir_pkg::dist_t   distance_q8_o,
  output logic             zero_median_o,
  output logic             unknown_model_o
);
  import mir_pkg::*;

  back_state_e       state_q, state_d;
  model_t            model_q, model_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  sample_t           ans_q, ans_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DivW-1:0]   quo_q, quo_d;
  sample_t           rem_q, rem_d;
  logic              ovld_q, ovld_d;
  dist_t             dist_q, dist_d;
  logic              zf_q, zf_d, uf_q, uf_d;

  sample_t           cand;
  logic [IdxW-1:0]   cnt_sum;
  logic [SampleW:0]  rem_sh;
  logic              ge;
  logic [DivW-1:0]   scaled;
  logic              unk, zero, load;

  assign cand    = ans_q | (sample_t'(1) << bit_q);
  assign cnt_sum = cnt_q + IdxW'((idx_q != '0) && (rd_data_i < cand));
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, ans_q};
  assign scaled  = (model_q == ModelFixed) ? {quo_q[DivW-9:0], 8'h00} : quo_q;
  assign unk     = ~model_known(model_q);
  assign zero    = (ans_q == '0);

  assign busy_o          = (state_q != BkIdle);
  assign q_pop_o         = (state_q == BkIdle) & ~q_empty_i;
  assign rd_o.en         = (state_q == BkScan) & (idx_q < IdxW'(SampleCount));
  assign rd_o.addr       = idx_q[AddrW-1:0];
  assign out_valid_o     = ovld_q;
  assign distance_q8_o   = dist_q;
  assign zero_median_o   = zf_q;
  assign unknown_model_o = uf_q;

  always_comb begin
    state_d = state_q;
    model_d = model_q;
    bit_d   = bit_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    ans_d   = ans_q;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dist_d  = dist_q;
    zf_d    = zf_q;
    uf_d    = uf_q;
    load    = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          model_d = q_model_i;
          bit_d   = BitW'(SampleW - 1);
          idx_d   = '0;
          cnt_d   = '0;
          ans_d   = '0;
          state_d = BkScan;
        end
      end
      BkScan: begin
        if (idx_q == IdxW'(SampleCount)) begin
          if (cnt_sum <= IdxW'(MedRank)) ans_d = cand;
          idx_d = '0;
          cnt_d = '0;
          if (bit_q == '0) begin
            step_d  = '0;
            quo_d   = curve_k(model_q);
            rem_d   = '0;
            state_d = BkDiv;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_sum;
        end
      end
      BkDiv: begin
        if (unk || zero) begin
          state_d = BkDone;
        end else begin
          quo_d  = {quo_q[DivW-2:0], ge};
          rem_d  = ge ? SampleW'(rem_sh - {1'b0, ans_q}) : rem_sh[SampleW-1:0];
          step_d = step_q + 1'b1;
          if (step_q == StepW'(DivW - 1)) state_d = BkDone;
        end
      end
      BkDone: begin
        if (!ovld_q || !out_stall_i) begin
          load    = 1'b1;
          uf_d    = unk;
          zf_d    = ~unk & zero;
          if (unk)       dist_d = '0;
          else if (zero) dist_d = DistMax;
          else           dist_d = {1'b0, scaled} - DistW'(curve_off(model_q));
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
    ovld_d = load ? 1'b1 : (ovld_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ovld_q  <= 1'b0;
      bit_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      bit_q   <= bit_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    model_q <= model_d;
    ans_q   <= ans_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dist_q  <= dist_d;
    zf_q    <= zf_d;
    uf_q    <= uf_d;
  end

endmodule

// File: hw/rtl/median_ir_distance_converter.sv
// Samples are taken one beat per cycle while the input is not stalled. The 25th sample of a batch
// closes it; the input then stalls while the back end finds the median in ten passes over the
// sample memory (one read port) and runs a bit-serial divide. A zero median or an unknown model
// skips the divide. The stall runs on while the previous result still waits in the output
// register when the new one is ready. A result waiting in the output register does not stop the
// next batch from being gathered.
// Top level; depends on mir_pkg, mir_front, mir_queue, mir_back.
module median_ir_distance_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  mir_pkg::model_t  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mir_pkg::sample_t adc_sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mir_pkg::dist_t   distance_q8_o,
  output logic             zero_median_o,
  output logic             unknown_model_o
);
  import mir_pkg::*;

  logic    push, pop, q_empty, busy;
  model_t  f_model, q_model;
  rd_req_t rd;
  sample_t rd_data;

  mir_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .adc_sample_i,
    .in_stall_o,
    .hold_i    (busy | ~q_empty),
    .push_o    (push),
    .model_o   (f_model),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  mir_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (f_model),
    .pop_i       (pop),
    .pop_data_o  (q_model),
    .empty_o     (q_empty)
  );

  mir_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .q_model_i (q_model),
    .q_pop_o   (pop),
    .busy_o    (busy),
    .rd_o      (rd),
    .rd_data_i (rd_data),
    .out_valid_o, .out_stall_i, .distance_q8_o, .zero_median_o, .unknown_model_o
  );

endmodule

// File: hw/rtl/mir_checker.sv
// Port-level checks for the median IR distance converter, bound to the top level.
// Depends on mir_pkg.
module mir_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input mir_pkg::dist_t  distance_q8_o,
  input logic            zero_median_o,
  input logic            unknown_model_o
);
  import mir_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_q8_o))
    else $error("stalled result beat changed");

  a_unk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_model_o |-> distance_q8_o == '0 && !zero_median_o)
    else $error("unknown model beat not zero");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_median_o |-> distance_q8_o == DistMax)
    else $error("zero median beat not saturated");

endmodule

bind median_ir_distance_converter mir_checker u_mir_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .distance_q8_o, .zero_median_o,
  .unknown_model_o
);

// File: dv/median_ir_distance_converter_tb.sv
// Testbench for median_ir_distance_converter: random and directed sample beats,
// batch median and calibration-curve predictor, scoreboard class. Depends on mir_pkg.
`timescale 1ns / 1ps

module median_ir_distance_converter_tb;
  import mir_pkg::*;

  localparam int Batch    = 25;
  localparam int WdLimit  = 20000;
  localparam int Drain    = 400;

  typedef struct packed {
    dist_t dval;
    logic  zero;
    logic  unk;
  } range_res_t;

  class range_scoreboard;
    logic [9:0]  held [Batch];
    int          held_n;
    logic [2:0]  curve;
    range_res_t  pending [$];
    int          errors;

    function void clear();
      held_n = 0;
      curve = 3'd1;
      errors = 0;
    endfunction

    function logic [9:0] median_of_batch();
      logic [9:0] s [Batch];
      logic [9:0] v;
      int j;
      s = held;
      for (int i = 1; i < Batch; i++) begin
        v = s[i];
        j = i;
        while (j > 0 && s[j-1] > v) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = v;
      end
      return s[Batch/2];
    endfunction

    function void note_sample(logic [9:0] smp);
      logic [9:0] med;
      range_res_t r;
      int k;
      int o;
      held[held_n] = smp;
      held_n++;
      if (held_n < Batch) return;
      held_n = 0;
      med = median_of_batch();
      r = '0;
      case (curve)
        3'd1: begin k = 5732;    o = 959;  end
        3'd2: begin k = 1463667; o = 1814; end
        3'd3: begin k = 1393236; o = 1789; end
        3'd4: begin k = 1452103; o = 886;  end
        3'd5: begin k = 1490931; o = 1027; end
        3'd6: begin k = 3870139; o = 6171; end
        default: begin k = 0; o = 0; end
      endcase
      if (curve == 3'd0 || curve == 3'd7) r.unk = 1'b1;
      else if (med == 0) begin
        r.zero = 1'b1;
        r.dval = DistMax;
      end else if (curve == 3'd1) r.dval = dist_t'((k / int'(med)) * 256 - o);
      else r.dval = dist_t'(k / int'(med) - o);
      pending.push_back(r);
    endfunction

    function void check_result(dist_t d, logic z, logic u);
      range_res_t e;
      if (pending.size() == 0) begin
        $error("result with none expected: distance_q8 %0d", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d !== e.dval) begin
        $error("distance_q8 expected %0d actual %0d", e.dval, d);
        errors++;
      end
      if (z !== e.zero) begin
        $error("zero_median expected %0b actual %0b", e.zero, z);
        errors++;
      end
      if (u !== e.unk) begin
        $error("unknown_model expected %0b actual %0b", e.unk, u);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  model_t cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  sample_t adc_sample_i;
  logic out_valid_o, out_stall_i;
  dist_t distance_q8_o;
  logic zero_median_o, unknown_model_o;

  range_scoreboard sb;
  int in_idle_pct, out_idle_pct;
  int quiet;

  median_ir_distance_converter uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .adc_sample_i,
    .out_valid_o, .out_stall_i, .distance_q8_o, .zero_median_o, .unknown_model_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    adc_sample_i = '0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    sb = new();
    sb.clear();
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stall, check on accepted beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(distance_q8_o, zero_median_o,
                                                       unknown_model_o);
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) quiet <= 0;
    else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else if (quiet >= WdLimit) begin
      $display("** median_ir_distance_converter: FAILED **");
      $finish;
    end else quiet <= quiet + 1;
  end

  task automatic send_sample(logic [9:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(smp);
  endtask

  task automatic end_beats();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_curve(model_t m);
    end_beats();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.curve = m;
  endtask

  task automatic send_batch(int kind);
    logic [9:0] base;
    base = 10'($urandom);
    for (int i = 0; i < Batch; i++) begin
      case (kind)
        0: send_sample(10'($urandom));
        1: send_sample(10'($urandom_range(3)));
        2: send_sample(10'($urandom_range(1023, 1000)));
        default: send_sample(base + 10'($urandom_range(8)));
      endcase
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // Directed: zero median at reset curve, then full-scale median.
    for (int i = 0; i < Batch; i++) send_sample(i < 13 ? 10'd0 : 10'd1023);
    for (int i = 0; i < Batch; i++) send_sample(i < 12 ? 10'd0 : 10'd1023);
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = ph == 0 ? 30 : ph == 1 ? 60 : 0;
      out_idle_pct = ph == 0 ? 60 : ph == 1 ? 30 : 0;
      for (int m = 0; m < 8; m++) begin
        write_curve(model_t'(m));
        send_batch((m + ph) % 4);
        if (m == 3) begin
          for (int i = 0; i < Batch; i++) send_sample(10'd1);
        end
      end
    end
    end_beats();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (sb.errors == 0) $display("** median_ir_distance_converter: PASSED **");
    else $display("** median_ir_distance_converter: FAILED **");
    $finish;
  end

endmodule
